/* rtl/core/gcb_pkg.sv */
// gcb_pkg: shared types and constants for the grapheme cluster boundary core.
// No dependencies; used by gcb_classify, gcb_result_fifo and the top level.
package gcb_pkg;

    // Field widths fixed by the interface
    localparam int CP_W    = 21;
    localparam int BC_W    = 3;
    localparam int KEPT_W  = 6;
    localparam int COUNT_W = 8;

    // Special code points
    localparam logic [CP_W-1:0] CP_ZWJ      = 21'h0200D;
    localparam logic [CP_W-1:0] CP_CR       = 21'h0000D;
    localparam logic [CP_W-1:0] CP_LF       = 21'h0000A;
    localparam logic [CP_W-1:0] CP_RI_FIRST = 21'h1F1E6;
    localparam logic [CP_W-1:0] CP_RI_LAST  = 21'h1F1FF;

    // Combining mark and variation selector ranges, inclusive
    localparam int MARK_RANGES = 20;

    localparam logic [CP_W-1:0] MARK_LO [MARK_RANGES] = '{
        21'h00300, 21'h00483, 21'h00591, 21'h005BF, 21'h005C1,
        21'h005C4, 21'h005C7, 21'h00610, 21'h0064B, 21'h00670,
        21'h006D6, 21'h006DF, 21'h00900, 21'h0093A, 21'h01AB0,
        21'h01DC0, 21'h020D0, 21'h0FE00, 21'h0FE20, 21'hE0100
    };

    localparam logic [CP_W-1:0] MARK_HI [MARK_RANGES] = '{
        21'h0036F, 21'h00489, 21'h005BD, 21'h005BF, 21'h005C2,
        21'h005C5, 21'h005C7, 21'h0061A, 21'h0065F, 21'h00670,
        21'h006DC, 21'h006E4, 21'h00903, 21'h0094F, 21'h01AFF,
        21'h01DFF, 21'h020F0, 21'h0FE0F, 21'h0FE2F, 21'hE01EF
    };

    // Result queue depth (power of two)
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // Character class flags of one code point
    typedef struct packed {
        logic is_mark;
        logic is_ri;
        logic is_zwj;
        logic is_cr;
        logic is_lf;
    } class_t;

    // One finished cluster
    typedef struct packed {
        logic [KEPT_W-1:0]  kept_bytes;
        logic [COUNT_W-1:0] point_count;
        logic               truncated;
        logic               last_of_run;
    } result_t;

    // Write request into the result queue; en1 is only set together with en0
    typedef struct packed {
        logic    en0;
        result_t data0;
        logic    en1;
        result_t data1;
    } fifo_wr_t;

endpackage

/* rtl/core/gcb_classify.sv */
// gcb_classify: parallel range compares that classify one code point.
// Depends on gcb_pkg for the range table and class_t.
module gcb_classify
(
    input  logic [gcb_pkg::CP_W-1:0] scalar_value,
    output gcb_pkg::class_t          cls
);

    logic mark_hit;

    // Any of the mark ranges matches
    always_comb
    begin
        mark_hit = 1'b0;
        for (int i = 0; i < gcb_pkg::MARK_RANGES; i++)
        begin
            if (scalar_value >= gcb_pkg::MARK_LO[i] && scalar_value <= gcb_pkg::MARK_HI[i])
            begin
                mark_hit = 1'b1;
            end
        end
    end

    // Single-value and regional indicator checks
    always_comb
    begin
        cls.is_mark = mark_hit;
        cls.is_ri   = (scalar_value >= gcb_pkg::CP_RI_FIRST) &&
                      (scalar_value <= gcb_pkg::CP_RI_LAST);
        cls.is_zwj  = (scalar_value == gcb_pkg::CP_ZWJ);
        cls.is_cr   = (scalar_value == gcb_pkg::CP_CR);
        cls.is_lf   = (scalar_value == gcb_pkg::CP_LF);
    end

endmodule

/* rtl/core/gcb_result_fifo.sv */
// gcb_result_fifo: small result queue taking up to two entries per cycle.
// Depends on gcb_pkg for result_t, fifo_wr_t and the queue depth.
module gcb_result_fifo
(
    input  logic              clk,
    input  logic              rst_n,
    input  gcb_pkg::fifo_wr_t wr,
    output logic              room_for_two,
    output logic              rd_valid,
    input  logic              rd_ready,
    output gcb_pkg::result_t  rd_data
);

    localparam int CNT_W = gcb_pkg::FIFO_AW + 1;

    gcb_pkg::result_t               mem [gcb_pkg::FIFO_DEPTH];
    logic [gcb_pkg::FIFO_AW-1:0]    wr_ptr_reg;
    logic [gcb_pkg::FIFO_AW-1:0]    wr_ptr_next;
    logic [gcb_pkg::FIFO_AW-1:0]    rd_ptr_reg;
    logic [gcb_pkg::FIFO_AW-1:0]    rd_ptr_next;
    logic [CNT_W-1:0]               count_reg;
    logic [CNT_W-1:0]               count_next;
    logic                           pop;

    assign pop          = rd_valid && rd_ready;
    assign rd_valid     = (count_reg != '0);
    assign rd_data      = mem[rd_ptr_reg];
    assign room_for_two = (count_reg <= CNT_W'(gcb_pkg::FIFO_DEPTH - 2));

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + gcb_pkg::FIFO_AW'(wr.en0) + gcb_pkg::FIFO_AW'(wr.en1);
        rd_ptr_next = rd_ptr_reg + gcb_pkg::FIFO_AW'(pop);
        count_next  = count_reg + CNT_W'(wr.en0) + CNT_W'(wr.en1) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage: first entry at the write pointer, second right after it
    always_ff @(posedge clk)
    begin
        if (wr.en0)
        begin
            mem[wr_ptr_reg] <= wr.data0;
        end
        if (wr.en1)
        begin
            mem[wr_ptr_reg + gcb_pkg::FIFO_AW'(1)] <= wr.data1;
        end
    end

endmodule

/* rtl/core/grapheme_cluster_boundary_core.sv */
// grapheme_cluster_boundary_core: top level of the grapheme cluster segmenter.
// Depends on gcb_pkg, gcb_classify and gcb_result_fifo.

// Takes one decoded code point per cycle and emits one request per finished
// cluster (kept bytes, saturating code point count, truncated flag, and a flag
// on the last result that a code point caused). The join decision and the
// cluster counters are a single registered pass, so a code point is accepted
// every cycle while the four-entry result queue has room for two requests; a
// result enters that queue when the code point that closed its cluster is
// accepted. A code point may cause two results (a closing cluster and the
// end-of-text cluster), and the output drains one result per cycle, so the
// sustained rate is one code point per cycle as long as results average no
// more than one per code point and the consumer keeps out_ready high.
module grapheme_cluster_boundary_core
#(
    parameter int MAX_CLUSTER_BYTES = 32
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [gcb_pkg::CP_W-1:0]    scalar_value,
    input  logic [gcb_pkg::BC_W-1:0]    byte_count,
    input  logic                        end_of_text,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [gcb_pkg::KEPT_W-1:0]  kept_bytes,
    output logic [gcb_pkg::COUNT_W-1:0] point_count,
    output logic                        truncated,
    output logic                        last_of_run
);

    localparam int BW = $clog2(MAX_CLUSTER_BYTES + 1);
    localparam logic [gcb_pkg::COUNT_W-1:0] COUNT_MAX = '1;

    gcb_pkg::class_t               cls;
    gcb_pkg::fifo_wr_t             wr;
    gcb_pkg::result_t              rd_data;
    gcb_pkg::result_t              close_res;
    gcb_pkg::result_t              eot_res;
    logic                          room_for_two;
    logic                          in_fire;

    logic                          have_prior_reg;
    logic                          have_prior_next;
    logic                          prior_zwj_reg;
    logic                          prior_zwj_next;
    logic                          prior_cr_reg;
    logic                          prior_cr_next;
    logic                          pair_open_reg;
    logic                          pair_open_next;
    logic [BW-1:0]                 bytes_reg;
    logic [BW-1:0]                 bytes_next;
    logic [gcb_pkg::COUNT_W-1:0]   points_reg;
    logic [gcb_pkg::COUNT_W-1:0]   points_next;
    logic                          lost_reg;
    logic                          lost_next;

    logic                          joins;
    logic                          close_open;
    logic [BW-1:0]                 base_bytes;
    logic [gcb_pkg::COUNT_W-1:0]   base_points;
    logic                          base_lost;
    logic [BW:0]                   byte_sum;
    logic [BW-1:0]                 upd_bytes;
    logic [gcb_pkg::COUNT_W-1:0]   upd_points;
    logic                          upd_lost;

    assign in_ready = room_for_two;
    assign in_fire  = in_valid && in_ready;

    gcb_classify u_classify
    (
        .scalar_value (scalar_value),
        .cls          (cls)
    );

    // Join decision against the previous code point
    always_comb
    begin
        joins = have_prior_reg &&
                (cls.is_mark || prior_zwj_reg || cls.is_zwj ||
                 (prior_cr_reg && cls.is_lf) || (cls.is_ri && pair_open_reg));
        close_open = !joins && (points_reg != '0);
    end

    // Cluster counters after adding this code point
    always_comb
    begin
        base_bytes  = joins ? bytes_reg  : '0;
        base_points = joins ? points_reg : '0;
        base_lost   = joins ? lost_reg   : 1'b0;

        upd_points = (base_points == COUNT_MAX) ? COUNT_MAX
                                                : base_points + gcb_pkg::COUNT_W'(1);
        byte_sum   = (BW + 1)'(base_bytes) + (BW + 1)'(byte_count);
        if (byte_sum > (BW + 1)'(MAX_CLUSTER_BYTES))
        begin
            upd_bytes = base_bytes;
            upd_lost  = 1'b1;
        end
        else
        begin
            upd_bytes = byte_sum[BW-1:0];
            upd_lost  = base_lost;
        end
    end

    // Results: the closed cluster first, then the end-of-text cluster
    always_comb
    begin
        close_res.kept_bytes  = gcb_pkg::KEPT_W'(bytes_reg);
        close_res.point_count = points_reg;
        close_res.truncated   = lost_reg;
        close_res.last_of_run = !end_of_text;

        eot_res.kept_bytes    = gcb_pkg::KEPT_W'(upd_bytes);
        eot_res.point_count   = upd_points;
        eot_res.truncated     = upd_lost;
        eot_res.last_of_run   = 1'b1;

        if (close_open)
        begin
            wr.en0   = in_fire;
            wr.data0 = close_res;
            wr.en1   = in_fire && end_of_text;
            wr.data1 = eot_res;
        end
        else
        begin
            wr.en0   = in_fire && end_of_text;
            wr.data0 = eot_res;
            wr.en1   = 1'b0;
            wr.data1 = eot_res;
        end
    end

    // Next state; end of text returns everything to reset
    always_comb
    begin
        if (end_of_text)
        begin
            have_prior_next = 1'b0;
            prior_zwj_next  = 1'b0;
            prior_cr_next   = 1'b0;
            pair_open_next  = 1'b0;
            bytes_next      = '0;
            points_next     = '0;
            lost_next       = 1'b0;
        end
        else
        begin
            have_prior_next = 1'b1;
            prior_zwj_next  = cls.is_zwj;
            prior_cr_next   = cls.is_cr;
            pair_open_next  = cls.is_ri && !joins;
            bytes_next      = upd_bytes;
            points_next     = upd_points;
            lost_next       = upd_lost;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_prior_reg <= 1'b0;
            prior_zwj_reg  <= 1'b0;
            prior_cr_reg   <= 1'b0;
            pair_open_reg  <= 1'b0;
            bytes_reg      <= '0;
            points_reg     <= '0;
            lost_reg       <= 1'b0;
        end
        else if (in_fire)
        begin
            have_prior_reg <= have_prior_next;
            prior_zwj_reg  <= prior_zwj_next;
            prior_cr_reg   <= prior_cr_next;
            pair_open_reg  <= pair_open_next;
            bytes_reg      <= bytes_next;
            points_reg     <= points_next;
            lost_reg       <= lost_next;
        end
    end

    gcb_result_fifo u_result_fifo
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr           (wr),
        .room_for_two (room_for_two),
        .rd_valid     (out_valid),
        .rd_ready     (out_ready),
        .rd_data      (rd_data)
    );

    assign kept_bytes  = rd_data.kept_bytes;
    assign point_count = rd_data.point_count;
    assign truncated   = rd_data.truncated;
    assign last_of_run = rd_data.last_of_run;

`ifndef SYNTHESIS
    // End of text leaves no open cluster and no history behind
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && end_of_text) |=> (points_reg == '0 && !have_prior_reg && !pair_open_reg))
        else $error("state not cleared after end of text");

    // Kept bytes never exceed the limit
    assert property (@(posedge clk) disable iff (!rst_n)
        bytes_reg <= BW'(MAX_CLUSTER_BYTES))
        else $error("cluster bytes above limit");

    // A cluster is open exactly when a prior code point exists
    assert property (@(posedge clk) disable iff (!rst_n)
        (points_reg != '0) == have_prior_reg)
        else $error("open cluster and prior flag disagree");

    // A pending regional indicator implies a prior code point
    assert property (@(posedge clk) disable iff (!rst_n)
        pair_open_reg |-> have_prior_reg)
        else $error("pair open without prior code point");
`endif

endmodule
